// ===== hw/rtl/array_list_engine_assert.svh =====
// Assertion macros for the array list engine.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define ALE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_list_engine: same-cycle check failed");
// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array_list_engine: next-cycle check failed");
`else
`define ALE_ASSERT_NOW(lbl, ante, cons)
`define ALE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/ale_pkg.sv =====
// Shared types and constants for the array list engine.
package ale_pkg;

    localparam int unsigned CAPACITY_DEF = 128;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    // Search wave passed from cell to cell.
    typedef struct packed {
        logic               hit;        // first match already seen
        logic               succ_pend;  // next active cell supplies successor
        logic               ok;
        logic signed [31:0] data;
        logic [7:0]         found;
    } carry_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         pos;
        logic signed [31:0] key;
        logic               shift_up;
        logic               shift_down;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/ale_cell.sv =====
// One list entry with its shift path and search-wave stage.
module ale_cell #(
    parameter int unsigned INDEX   = 0,
    parameter int unsigned COUNT_W = 8
) (
    input  logic                      clk,
    input  ale_pkg::cell_ctrl_t       ctrl,
    input  logic [COUNT_W-1:0]        count,
    input  logic signed [31:0]        left_value,
    input  logic signed [31:0]        right_value,
    input  ale_pkg::carry_t           carry_in,
    output logic signed [31:0]        value,
    output ale_pkg::carry_t           carry_out
);
    import ale_pkg::*;

    localparam int unsigned PW = (COUNT_W > 8) ? COUNT_W : 8;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    carry_t             carry_reg;
    carry_t             carry_next;
    logic               active;
    logic               at_pos;
    logic               above_pos;
    logic               match;

    assign active    = PW'(INDEX) < PW'(count);
    assign at_pos    = PW'(ctrl.pos) == PW'(INDEX + 1);
    assign above_pos = PW'(INDEX + 1) > PW'(ctrl.pos);
    assign match     = active && (value_reg == ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_up)
        begin
            if (at_pos)
            begin
                value_next = ctrl.key;
            end
            else if (above_pos)
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.shift_down)
        begin
            if (at_pos || above_pos)
            begin
                value_next = right_value;
            end
        end
    end

    always_comb
    begin
        carry_next = carry_in;
        unique case (op_t'(ctrl.op)) inside
            OP_DELETE, OP_GET:
            begin
                if (active && at_pos)
                begin
                    carry_next.ok   = 1'b1;
                    carry_next.data = value_reg;
                end
            end
            OP_LOCATE:
            begin
                if (match && !carry_in.hit)
                begin
                    carry_next.hit   = 1'b1;
                    carry_next.ok    = 1'b1;
                    carry_next.found = 8'(INDEX + 1);
                end
            end
            OP_PRED:
            begin
                if (match && !carry_in.hit)
                begin
                    carry_next.hit = 1'b1;
                    if (INDEX > 0)
                    begin
                        carry_next.ok   = 1'b1;
                        carry_next.data = left_value;
                    end
                end
            end
            OP_SUCC:
            begin
                if (carry_in.succ_pend && active)
                begin
                    carry_next.succ_pend = 1'b0;
                    carry_next.ok        = 1'b1;
                    carry_next.data      = value_reg;
                end
                if (match && !carry_in.hit)
                begin
                    carry_next.hit       = 1'b1;
                    carry_next.succ_pend = 1'b1;
                end
            end
            default:
            begin
                carry_next = carry_in;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        carry_reg <= carry_next;
    end

    assign value     = value_reg;
    assign carry_out = carry_reg;

endmodule

// ===== hw/rtl/array_list_engine.sv =====
// Top level of the array list engine: control, result registers, cell chain.
//
// Ordered list of up to CAPACITY signed 32-bit values, one value per cell in a
// row of cells. An item is transferred at a rising edge with start high and
// busy low; its one result is shown for exactly one cycle with done high and
// must be taken then, since the receiver cannot stall the block. Insert,
// clear and the unused opcode go straight from IDLE to DONE. Delete, get,
// locate, predecessor and successor first pass through SCAN: a search wave
// ripples through the cell chain one cell per clock, and the last cell's
// stage holds the answer; delete then shifts the entries down in the commit
// cycle. busy is low in the cycle that done is high, so the next item may be
// transferred there. Insert and delete move the entries from the position
// up in parallel, each cell above it taking its neighbor's value. There is
// no clearing pass after reset: entries past the list length are never read.
`include "array_list_engine_assert.svh"

module array_list_engine #(
    parameter int unsigned CAPACITY = ale_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               ok,
    output logic signed [31:0] data_out,
    output logic [7:0]         found_position,
    output logic [7:0]         list_length,
    output logic               is_empty
);
    import ale_pkg::*;

    localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned SCAN_W  = $clog2(CAPACITY);
    localparam int unsigned PW      = (COUNT_W > 8) ? COUNT_W : 8;
    localparam int unsigned CW      = PW + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] key_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SCAN_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic               done_reg;
    logic               ok_reg, ok_next;
    logic signed [31:0] data_reg, data_next;
    logic [7:0]         found_reg, found_next;
    logic [7:0]         length_reg;
    logic               empty_reg;

    logic               accept;
    logic               ins_valid;
    logic               scan_op;
    cell_ctrl_t         ctrl;
    carry_t             carry_last;

    logic signed [31:0] cell_value [CAPACITY];
    carry_t             cell_carry [CAPACITY];

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Ops that need the search wave through the chain.
    always_comb
    begin
        scan_op = 1'b0;
        case (op_t'(opcode)) inside
            OP_DELETE, OP_GET, OP_LOCATE, OP_PRED, OP_SUCC: scan_op = 1'b1;
            default:                                        scan_op = 1'b0;
        endcase
    end

    // Insert needs room and a position in 1..length+1.
    assign ins_valid = (CW'(count_reg) < CW'(CAPACITY)) && (pos_reg != 8'd0) &&
                       (CW'(pos_reg) <= CW'(count_reg) + CW'(1));

    assign carry_last = cell_carry[CAPACITY-1];

    // Command broadcast; shifts fire only in the commit cycle.
    always_comb
    begin
        ctrl.op         = op_reg;
        ctrl.pos        = pos_reg;
        ctrl.key        = key_reg;
        ctrl.shift_up   = (state_reg == ST_DONE) && (op_t'(op_reg) == OP_INSERT) && ins_valid;
        ctrl.shift_down = (state_reg == ST_DONE) && (op_t'(op_reg) == OP_DELETE) &&
                          carry_last.ok;
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_cnt_next = '0;
                    state_next    = scan_op ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == SCAN_W'(CAPACITY - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result and new length, formed in the commit cycle.
    always_comb
    begin
        ok_next    = 1'b0;
        data_next  = '0;
        found_next = '0;
        count_next = count_reg;
        case (op_t'(op_reg)) inside
            OP_INSERT:
            begin
                ok_next = ins_valid;
                if (ins_valid)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                ok_next   = carry_last.ok;
                data_next = carry_last.data;
                if (carry_last.ok)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_GET, OP_PRED, OP_SUCC:
            begin
                ok_next   = carry_last.ok;
                data_next = carry_last.data;
            end
            OP_LOCATE:
            begin
                ok_next    = carry_last.ok;
                found_next = carry_last.found;
            end
            OP_CLEAR:
            begin
                ok_next    = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= (state_reg == ST_DONE);
            if (state_reg == ST_DONE)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            key_reg <= value;
        end
        if (state_reg == ST_DONE)
        begin
            ok_reg     <= ok_next;
            data_reg   <= data_next;
            found_reg  <= found_next;
            length_reg <= 8'(count_next);
            empty_reg  <= (count_next == '0);
        end
    end

    // Cell chain: values shift between neighbors, the search wave moves right.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_v;
        logic signed [31:0] right_v;
        carry_t             carry_in;

        if (i == 0)
        begin : g_first
            assign left_v   = '0;
            assign carry_in = '0;
        end
        else
        begin : g_mid
            assign left_v   = cell_value[i-1];
            assign carry_in = cell_carry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_inner
            assign right_v = cell_value[i+1];
        end

        ale_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_value  (left_v),
            .right_value (right_v),
            .carry_in    (carry_in),
            .value       (cell_value[i]),
            .carry_out   (cell_carry[i])
        );
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign data_out       = data_reg;
    assign found_position = found_reg;
    assign list_length    = length_reg;
    assign is_empty       = empty_reg;

    // A transfer always leads to a busy cycle.
    `ALE_ASSERT_NEXT(a_accept_busy, accept, busy)
    // A result shows while the block is free for the next transfer.
    `ALE_ASSERT_NOW(a_done_idle, done, !busy)
    // One result per transfer: strobes never come back to back.
    `ALE_ASSERT_NEXT(a_done_single, done, !done)
    // Length stays within the store.
    `ALE_ASSERT_NOW(a_count_cap, 1'b1, CW'(count_reg) <= CW'(CAPACITY))

endmodule

// ===== verif/array_list_checker.sv =====
// Checker for the array list engine: tracks the list and compares every result.
`timescale 1ns / 1ps
module array_list_checker #(
    parameter int unsigned CAPACITY = ale_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         opcode,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    input  logic               done,
    input  logic               ok,
    input  logic signed [31:0] data_out,
    input  logic [7:0]         found_position,
    input  logic [7:0]         list_length,
    input  logic               is_empty,
    output int                 mismatches,
    output int                 results_outstanding
);
    import ale_pkg::*;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] data;
        logic [7:0]         found;
        logic [7:0]         length;
        logic               empty;
    } list_result_t;

    logic signed [31:0] cells [CAPACITY];
    int unsigned        entries = 0;
    list_result_t       results_due [$];
    int                 errs = 0;

    // 0-based index of the first cell equal to key; entries when absent.
    function automatic int unsigned first_hit(logic signed [31:0] key);
        int unsigned k;
        for (k = 0; k < entries; k++)
        begin
            if (cells[k] == key)
                return k;
        end
        return entries;
    endfunction

    // Applies one command to the list and returns the result it must produce.
    function automatic list_result_t apply_list_op(logic [2:0] op, logic [7:0] pos,
                                                   logic signed [31:0] key);
        list_result_t r;
        int unsigned  m;
        r = '0;
        m = first_hit(key);
        case (op)
            OP_INSERT:
                if (entries < CAPACITY && pos >= 1 && pos <= entries + 1)
                begin
                    for (int k = entries; k >= pos; k--)
                        cells[k] = cells[k - 1];
                    cells[pos - 1] = key;
                    entries++;
                    r.ok = 1'b1;
                end
            OP_DELETE:
                if (pos >= 1 && pos <= entries)
                begin
                    r.data = cells[pos - 1];
                    for (int k = pos; k < entries; k++)
                        cells[k - 1] = cells[k];
                    entries--;
                    r.ok = 1'b1;
                end
            OP_GET:
                if (pos >= 1 && pos <= entries)
                begin
                    r.data = cells[pos - 1];
                    r.ok = 1'b1;
                end
            OP_LOCATE:
                if (m < entries)
                begin
                    r.found = 8'(m + 1);
                    r.ok = 1'b1;
                end
            OP_PRED:
                if (m < entries && m > 0)
                begin
                    r.data = cells[m - 1];
                    r.ok = 1'b1;
                end
            OP_SUCC:
                if (m + 1 < entries)
                begin
                    r.data = cells[m + 1];
                    r.ok = 1'b1;
                end
            OP_CLEAR:
            begin
                entries = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.length = 8'(entries);
        r.empty = (entries == 0);
        return r;
    endfunction

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk)
    begin : compare_results
        list_result_t want;
        if (rst_n)
        begin
            // A result taken here belongs to an earlier transfer, so pop first.
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with nothing outstanding: data_out %0d", data_out);
                    errs++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("ok", want.ok, ok);
                    check_field("data_out", want.data, data_out);
                    check_field("found_position", want.found, found_position);
                    check_field("list_length", want.length, list_length);
                    check_field("is_empty", want.empty, is_empty);
                end
            end
            if (start && !busy)
                results_due.push_back(apply_list_op(opcode, position, value));
        end
        mismatches <= errs;
        results_outstanding <= results_due.size();
    end

endmodule

// ===== verif/tb_array_list_engine.sv =====
// Testbench top for the array list engine: clock, reset, command stimulus, verdict.
`timescale 1ns / 1ps
module tb_array_list_engine;
    import ale_pkg::*;

    localparam int unsigned        DEPTH        = CAPACITY_DEF;
    localparam logic [2:0]         OP_UNUSED    = 3'd7;   // no operation behind it
    localparam int                 RANDOM_ITEMS = 1400;
    // The gap overlaps the search, so even the slowest correct run stays well
    // below this limit.
    localparam int                 CYCLE_LIMIT  = 1_000_000;
    localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX      = 32'sh7fff_ffff;

    // Workload mix of the random part.
    typedef enum {GROW, SHRINK, MIX} load_phase_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         opcode = '0;
    logic [7:0]         position = '0;
    logic signed [31:0] value = '0;
    logic               busy;
    logic               done;
    logic               ok;
    logic signed [31:0] data_out;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
    logic               is_empty;

    int                 mismatches;
    int                 results_outstanding;

    // Sender's own idea of the list length; only used to aim positions so
    // that most commands land on valid entries.
    int                 list_len = 0;
    int                 burst_left = 0;
    logic signed [31:0] value_pool [12];
    int                 cycles = 0;

    always #1 clk = ~clk;

    array_list_engine #(.CAPACITY(DEPTH)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .position       (position),
        .value          (value),
        .done           (done),
        .ok             (ok),
        .data_out       (data_out),
        .found_position (found_position),
        .list_length    (list_length),
        .is_empty       (is_empty)
    );

    array_list_checker #(.CAPACITY(DEPTH)) list_monitor (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .opcode              (opcode),
        .position            (position),
        .value               (value),
        .done                (done),
        .ok                  (ok),
        .data_out            (data_out),
        .found_position      (found_position),
        .list_length         (list_length),
        .is_empty            (is_empty),
        .mismatches          (mismatches),
        .results_outstanding (results_outstanding)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("array_list_engine regression: fail");
            $finish;
        end
    end

    // Values mostly come from a small pool so that searches hit often and
    // duplicates make "first match" matter; a few are fully random.
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 11)];
    endfunction

    // Insert positions: mostly 1..len+1, plus zero, just past the end, and noise.
    function automatic logic [7:0] insert_pos();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1:       return 8'(list_len + 1 + $urandom_range(0, 1));
            2:       return 8'd0;
            default: return 8'($urandom_range(1, list_len + 1));
        endcase
    endfunction

    // Delete/get positions: mostly 1..len, plus zero, the last entry, one past it.
    function automatic logic [7:0] index_pos();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom);
            1:       return 8'd0;
            2:       return 8'(list_len + $urandom_range(0, 1));
            default: return (list_len > 0) ? 8'($urandom_range(1, list_len))
                                           : 8'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [2:0] pick_op(load_phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0)
            return OP_UNUSED;
        if (r == 1 && ph == MIX)
            return OP_CLEAR;
        case (ph)
            GROW:
                if (r < 80)
                    return OP_INSERT;
                else if (r < 84)
                    return OP_DELETE;
            SHRINK:
                if (r < 55)
                    return OP_DELETE;
                else if (r < 65)
                    return OP_INSERT;
            default:
                if (r < 30)
                    return OP_INSERT;
                else if (r < 50)
                    return OP_DELETE;
        endcase
        case (r % 4)
            0:       return OP_GET;
            1:       return OP_LOCATE;
            2:       return OP_PRED;
            default: return OP_SUCC;
        endcase
    endfunction

    // One command transfer. start stays high across back-to-back transfers;
    // between bursts it drops for a random gap, long enough at times to land
    // anywhere in a full search.
    task automatic issue(input logic [2:0] op, input logic [7:0] pos,
                         input logic signed [31:0] val);
        int gap;
        start <= 1'b1;
        opcode <= op;
        position <= pos;
        value <= val;
        do
            @(posedge clk);
        while (busy);
        case (op)
            OP_INSERT:
                if (list_len < DEPTH && pos >= 1 && pos <= list_len + 1)
                    list_len++;
            OP_DELETE:
                if (pos >= 1 && pos <= list_len)
                    list_len--;
            OP_CLEAR:
                list_len = 0;
            default: ;
        endcase
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DEPTH + 12)
                                              : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            // Now and then a long burst with no idle cycles at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold off until every outstanding result has come back. The first edge
    // lets the count catch up with a transfer taken at the current edge.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    task automatic refresh_pool();
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 12; i++)
            value_pool[i] = $urandom;
    endtask

    initial
    begin : stimulus
        load_phase_t ph;
        int          phase_left;
        logic [2:0]  op;
        logic [7:0]  pos;

        refresh_pool();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: everything fails on an empty list.
        issue(OP_GET, 8'd1, '0);
        issue(OP_DELETE, 8'd1, '0);
        issue(OP_LOCATE, 8'd0, '0);
        issue(OP_PRED, 8'd0, '0);
        // Insert at position zero and past the end are rejected.
        issue(OP_INSERT, 8'd0, 32'sd5);
        issue(OP_INSERT, 8'd2, 32'sd5);
        // Build MIN, 0, MAX, -1, MIN, 5: front, middle and end inserts,
        // with a duplicate of the first entry.
        issue(OP_INSERT, 8'd1, VAL_MAX);
        issue(OP_INSERT, 8'd1, VAL_MIN);
        issue(OP_INSERT, 8'd3, -32'sd1);
        issue(OP_INSERT, 8'd2, '0);
        issue(OP_INSERT, 8'd5, VAL_MIN);
        issue(OP_INSERT, 8'd6, 32'sd5);
        // First match wins; predecessor of the first entry and successor of
        // the last entry both fail.
        issue(OP_LOCATE, 8'd0, VAL_MIN);
        issue(OP_LOCATE, 8'd0, -32'sd1);
        issue(OP_PRED, 8'd0, VAL_MIN);
        issue(OP_PRED, 8'd0, -32'sd1);
        issue(OP_SUCC, 8'd0, -32'sd1);
        issue(OP_SUCC, 8'd0, 32'sd5);
        // Get at zero is rejected; last entry is fine.
        issue(OP_GET, 8'd0, '0);
        issue(OP_GET, 8'd6, '0);
        issue(OP_DELETE, 8'd1, '0);
        issue(OP_DELETE, 8'd255, '0);
        // Unused opcode leaves the list alone; clear empties it.
        issue(OP_UNUSED, 8'd3, VAL_MAX);
        issue(OP_CLEAR, 8'd0, '0);
        issue(OP_GET, 8'd1, '0);

        // Let the block go fully quiet once before the random part.
        wait_drained();

        // First phase fills the list so full-list inserts get exercised early.
        ph = GROW;
        phase_left = 300;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                ph = load_phase_t'($urandom_range(0, 2));
                phase_left = $urandom_range(60, 260);
                refresh_pool();
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
            phase_left--;
            op = pick_op(ph);
            case (op) inside
                OP_INSERT:         pos = insert_pos();
                OP_DELETE, OP_GET: pos = index_pos();
                default:           pos = 8'($urandom);
            endcase
            issue(op, pos, pick_value());
        end

        // Drain, then leave room for any stray result to show up.
        wait_drained();
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatches == 0)
            $display("array_list_engine regression: pass");
        else
            $display("array_list_engine regression: fail");
        $finish;
    end

endmodule
